### sv/assert_macros.svh
// Assertion helper macros for the SHA-256 stream hasher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on clock edges outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values, FSM states and control structs.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    typedef logic [31:0] word_t;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_byte;   // store s byte, advance fill and length
        logic pad_start;   // place marker, zero the rest of the block
        logic pad_length;  // write bit length into last eight bytes
        logic clear_block; // zero the block buffer
        logic comp_start;  // copy hash words into working variables
        logic round_step;  // run one compression round
        logic fold;        // add working variables into hash words
        logic msg_reset;   // restore initial hash, clear fill and length
        logic emit_next;   // advance digest word index
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic block_full;  // fill reached 64 bytes with this load
        logic pad_extra;   // marker landed at byte 56 or beyond
        logic last_round;  // round counter at 63
        logic last_emit;   // digest word index at 7
    } status_t;

endpackage

### sv/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with digest emitted as eight 32-bit items.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while idle; a byte that fills a block starts 64 rounds and a fold.
// End of message: each padding block runs pad, 64 rounds and fold, then eight items follow.
// No byte is taken during pad, rounds, fold or output, since the single round unit is shared.
// Reset: aresetn synchronous active low; hash words return to the initial values.
module sha256_stream_hasher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic        s_tlast,   // is_last
    input  logic        s_tuser,   // empty_msg
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    sha256_pkg::cmd_t    cmd;
    sha256_pkg::status_t status;
    logic [2:0]          idx;

    sha256_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_last(s_tlast), .in_empty(s_tuser), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .status(status)
    );

    sha256_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .byte_in(s_tdata),
        .status(status), .digest_word(m_tdata), .word_index(idx)
    );

    assign m_tuser = idx;
    assign m_tlast = (idx == 3'd7);

endmodule

### sv/sha256_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, round logic, hash words and length count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha256_pkg::cmd_t    cmd,
    input  logic [7:0]          byte_in,
    output sha256_pkg::status_t status,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index
);

    sha256_pkg::word_t         block_reg [16];
    sha256_pkg::word_t         blk_next [16];
    logic [5:0]                fill_reg;
    logic [63:0]               bits_reg;
    sha256_pkg::word_t         hash_reg [8];
    sha256_pkg::word_t         v_reg [8];
    sha256_pkg::word_t         w_reg [16];
    logic [5:0]                round_reg;
    logic [2:0]                emit_reg;

    sha256_pkg::word_t w_cur, w15, w2, s0, s1, e, a, t1, t2;
    logic [3:0] slot;
    logic       wrap_step;

    always_comb begin
        slot = round_reg[3:0];
        w15  = w_reg[slot + 4'd1];
        w2   = w_reg[slot + 4'd14];
        s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        if (round_reg < 6'd16) begin
            w_cur = block_reg[slot];
        end else begin
            w_cur = w_reg[slot] + s0 + w_reg[slot + 4'd9] + s1;
        end
        e  = v_reg[4];
        a  = v_reg[0];
        t1 = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha256_pkg::ROUND_K[round_reg]
             + w_cur;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        for (int k = 0; k < 16; k++) blk_next[k] = block_reg[k];
        if (cmd.clear_block) begin
            for (int k = 0; k < 16; k++) blk_next[k] = '0;
        end
        if (cmd.load_byte) begin
            blk_next[fill_reg[5:2]][{~fill_reg[1:0], 3'd0} +: 8] = byte_in;
        end
        if (cmd.pad_start) begin
            for (int k = 0; k < 16; k++) begin
                for (int j = 0; j < 4; j++) begin
                    if (6'(4 * k + j) == fill_reg) begin
                        blk_next[k][24 - 8 * j +: 8] = sha256_pkg::PAD_MARKER;
                    end else if (6'(4 * k + j) > fill_reg) begin
                        blk_next[k][24 - 8 * j +: 8] = '0;
                    end
                end
            end
        end
        if (cmd.pad_length) begin
            blk_next[14] = bits_reg[63:32];
            blk_next[15] = bits_reg[31:0];
        end
    end

    assign status.block_full = (fill_reg == 6'd63);
    assign status.pad_extra  = (fill_reg >= 6'd56);
    assign status.last_round = (round_reg == 6'd63);
    assign status.last_emit  = (emit_reg == 3'd7);
    assign digest_word = hash_reg[emit_reg];
    assign word_index  = emit_reg;
    assign wrap_step   = cmd.round_step && (round_reg == 6'd63);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.msg_reset) begin
            fill_reg <= '0;
            bits_reg <= '0;
            for (int k = 0; k < 8; k++) hash_reg[k] <= sha256_pkg::INIT_HASH[k];
            for (int k = 0; k < 16; k++) block_reg[k] <= '0;
        end else begin
            for (int k = 0; k < 16; k++) block_reg[k] <= blk_next[k];
            if (cmd.load_byte) begin
                fill_reg <= fill_reg + 6'd1;
                bits_reg <= bits_reg + 64'd8;
            end
            if (cmd.fold) begin
                for (int k = 0; k < 8; k++) hash_reg[k] <= hash_reg[k] + v_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.comp_start) begin
            for (int k = 0; k < 8; k++) v_reg[k] <= hash_reg[k];
        end else if (cmd.round_step) begin
            w_reg[slot] <= w_cur;
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg <= '0;
            emit_reg  <= '0;
        end else begin
            if (cmd.comp_start) round_reg <= '0;
            else if (cmd.round_step) round_reg <= round_reg + 6'd1;
            if (cmd.msg_reset) emit_reg <= '0;
            else if (cmd.emit_next) emit_reg <= emit_reg + 3'd1;
        end
    end

    `ASSERT_CLK(a_fill_frozen, aclk, aresetn, cmd.round_step |=> $stable(fill_reg), "fill moved")
    `ASSERT_CLK(a_round_wrap, aclk, aresetn, wrap_step |=> round_reg == 6'd0, "no round wrap")
    `ASSERT_CLK(a_no_overlap, aclk, aresetn, !(cmd.load_byte && cmd.round_step), "load in rounds")

endmodule

### sv/sha256_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, compressions, padding and digest output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_last,
    input  logic                in_empty,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output sha256_pkg::cmd_t    cmd,
    input  sha256_pkg::status_t status
);

    sha256_pkg::state_t state_reg, state_next;
    logic fin_reg, fin_next;   // a padding block follows this compression
    logic len_reg, len_next;   // the pending compression is the length block
    // extra padding block done: clear the block, then write the length only
    logic pad_tail_reg, pad_tail_next;
    logic last_step;

    wire accept = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        len_next   = len_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_empty) state_next = sha256_pkg::ST_PAD;
                    else if (status.block_full) begin
                        state_next = sha256_pkg::ST_ROUND;
                        fin_next = in_last;
                        len_next = 1'b0;
                    end else if (in_last) state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (status.last_round) state_next = sha256_pkg::ST_FOLD;
            end
            sha256_pkg::ST_FOLD: begin
                if (len_reg) state_next = sha256_pkg::ST_EMIT;
                else if (fin_reg) state_next = sha256_pkg::ST_PAD;
                else state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_PAD: begin
                state_next = sha256_pkg::ST_ROUND;
                len_next = !status.pad_extra || pad_tail_reg;
                fin_next = status.pad_extra && !pad_tail_reg;
            end
            sha256_pkg::ST_EMIT: begin
                if (out_ready && status.last_emit) state_next = sha256_pkg::ST_IDLE;
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pad_tail_next = pad_tail_reg;
        if (state_reg == sha256_pkg::ST_PAD) begin
            pad_tail_next = status.pad_extra && !pad_tail_reg;
        end
    end

    always_comb begin
        cmd = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            sha256_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load_byte  = in_valid && !in_empty;
                cmd.comp_start = in_valid && !in_empty && status.block_full;
            end
            sha256_pkg::ST_ROUND: cmd.round_step = 1'b1;
            sha256_pkg::ST_FOLD: begin
                cmd.fold = 1'b1;
                if (pad_tail_reg) begin
                    cmd.clear_block = 1'b1;
                end
            end
            sha256_pkg::ST_PAD: begin
                cmd.comp_start = 1'b1;
                if (!pad_tail_reg) cmd.pad_start = 1'b1;
                if (!status.pad_extra || pad_tail_reg) cmd.pad_length = 1'b1;
            end
            sha256_pkg::ST_EMIT: begin
                out_valid = 1'b1;
                cmd.emit_next = out_ready;
                cmd.msg_reset = out_ready && status.last_emit;
            end
            default: ;
        endcase
    end

    assign last_step = cmd.round_step && status.last_round;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha256_pkg::ST_IDLE;
            fin_reg      <= 1'b0;
            len_reg      <= 1'b0;
            pad_tail_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fin_reg      <= fin_next;
            len_reg      <= len_next;
            pad_tail_reg <= pad_tail_next;
        end
    end

    `ASSERT_CLK(a_excl, aclk, aresetn, !(in_ready && out_valid), "input and output open")
    `ASSERT_CLK(a_emit_hold, aclk, aresetn, (out_valid && !out_ready) |=> out_valid, "item dropped")
    `ASSERT_CLK(a_fold_after, aclk, aresetn, last_step |=> cmd.fold, "fold missed")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams byte messages of varied length into the hasher, computes each digest
// with an internal SHA-256 predictor and checks every digest word, its index
// and its last flag, under random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------

class digest_board;
    logic [31:0] hash_st [8];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] nbits;
    logic [31:0] exp_word [$];
    logic [2:0]  exp_idx [$];
    logic        exp_lastw [$];
    int          errors;

    function new();
        errors = 0;
        clear_msg();
    endfunction

    function void clear_msg();
        for (int k = 0; k < 8; k++) hash_st[k] = sha256_pkg::INIT_HASH[k];
        for (int k = 0; k < 64; k++) blk[k] = 8'h00;
        fill = 0;
        nbits = 64'd0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, e, a, s0, s1;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
            end else begin
                s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = w[r-16] + s0 + w[r-7] + s1;
            end
        end
        for (int k = 0; k < 8; k++) v[k] = hash_st[k];
        for (int r = 0; r < 64; r++) begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
                 + ((e & v[5]) ^ (~e & v[6])) + sha256_pkg::ROUND_K[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
                 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++) hash_st[k] = hash_st[k] + v[k];
    endfunction

    function void finish_msg();
        blk[fill] = sha256_pkg::PAD_MARKER;
        for (int k = fill + 1; k < 64; k++) blk[k] = 8'h00;
        if (fill >= 56) begin
            compress();
            for (int k = 0; k < 64; k++) blk[k] = 8'h00;
        end
        for (int k = 0; k < 8; k++) blk[63-k] = nbits[8*k +: 8];
        compress();
        for (int k = 0; k < 8; k++) begin
            exp_word  = {exp_word, hash_st[k]};
            exp_idx   = {exp_idx, 3'(k)};
            exp_lastw = {exp_lastw, (k == 7)};
        end
        clear_msg();
    endfunction

    function void note_byte(logic [7:0] b, logic lst, logic emp);
        if (emp) begin
            finish_msg();
            return;
        end
        blk[fill] = b;
        fill++;
        nbits += 64'd8;
        if (fill == 64) begin
            compress();
            fill = 0;
        end
        if (lst) finish_msg();
    endfunction

    function int pending();
        return exp_word.size();
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_word(logic [31:0] d, logic [2:0] idx, logic lw);
        logic [31:0] ew;
        logic [2:0]  ei;
        logic        el;
        if (exp_word.size() == 0) begin
            report($sformatf("unexpected word %h", d));
            return;
        end
        ew = exp_word.pop_front();
        ei = exp_idx.pop_front();
        el = exp_lastw.pop_front();
        if (d !== ew) report($sformatf("word %0d got %h want %h", ei, d, ew));
        if (idx !== ei) report($sformatf("index got %0d want %0d", idx, ei));
        if (lw !== el) report($sformatf("last at %0d got %b want %b", ei, lw, el));
    endtask
endclass

module tb;
    localparam int HOLD_CYCLES = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        hold_req = 1'b0;

    digest_board board = new();
    int send_idle_pct = 22;
    int recv_idle_pct = 73;
    int hold_off = 0;

    sha256_stream_hasher_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        if (hold_req) begin
            m_tready <= 1'b0;
            hold_off <= HOLD_CYCLES;
        end else if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic [7:0] b, logic lst, logic emp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= lst;
        s_tuser <= emp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_byte(b, lst, emp);
    endtask

    task automatic send_msg(int len, int how);
        for (int k = 0; k < len; k++) begin
            if (k == len - 1 && how == 0) send_item(8'($urandom), 1'b1, 1'b0);
            else send_item(8'($urandom), 1'b0, 1'b0);
        end
        if (how == 1 || len == 0) send_item(8'($urandom), 1'($urandom), 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    int plen;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b1);
        send_msg(3, 0);
        drain();
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        send_msg(56, 0);
        send_msg(3, 0);
        drain();
        send_msg(64, 1);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 73;
                recv_idle_pct = 22;
            end
            if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 4; n++) begin
                case ($urandom_range(9))
                    0: plen = 55 + $urandom_range(9);
                    1: plen = 0;
                    default: plen = $urandom_range(20, 1);
                endcase
                send_msg(plen, $urandom_range(2) == 0 ? 1 : 0);
            end
            drain();
        end
        if (board.pending() == 0 && board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
